// ===== design/ddo_pkg.sv =====
// Package for the differential drive odometry unit.
// Holds the CORDIC arctangent table and shared constants; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ddo_pkg;

    localparam int unsigned AtanDepth = 31;
    localparam logic [31:0] CordicStartX = 32'd652032874;
    localparam logic [31:0] RadToBam = 32'd683565276;

    localparam logic [1:0] RegWheelRadius = 2'd0;
    localparam logic [1:0] RegInvWheelBase = 2'd1;
    localparam logic [1:0] RegSamplePeriod = 2'd2;

    function automatic logic [29:0] atan_bam(input logic [4:0] idx);
        logic [29:0] v;
        begin
            case (idx)
                5'd0: v = 30'd536870912;
                5'd1: v = 30'd316933406;
                5'd2: v = 30'd167458907;
                5'd3: v = 30'd85004756;
                5'd4: v = 30'd42667331;
                5'd5: v = 30'd21354465;
                5'd6: v = 30'd10680862;
                5'd7: v = 30'd5340245;
                5'd8: v = 30'd2670163;
                5'd9: v = 30'd1335087;
                5'd10: v = 30'd667544;
                5'd11: v = 30'd333772;
                5'd12: v = 30'd166886;
                5'd13: v = 30'd83443;
                5'd14: v = 30'd41722;
                5'd15: v = 30'd20861;
                5'd16: v = 30'd10430;
                5'd17: v = 30'd5215;
                5'd18: v = 30'd2608;
                5'd19: v = 30'd1304;
                5'd20: v = 30'd652;
                5'd21: v = 30'd326;
                5'd22: v = 30'd163;
                5'd23: v = 30'd81;
                5'd24: v = 30'd41;
                5'd25: v = 30'd20;
                5'd26: v = 30'd10;
                5'd27: v = 30'd5;
                5'd28: v = 30'd3;
                5'd29: v = 30'd1;
                5'd30: v = 30'd1;
                default: v = 30'd0;
            endcase
            return v;
        end
    endfunction

endpackage
`default_nettype wire

// ===== design/diff_drive_odometry_unit.sv =====
// Differential drive odometry unit: top level with sequencer and shared multiplier.
// Depends on ddo_pkg and ddo_cordic.
//
// Usage: wheel speed samples arrive as transfers on the s_axis channel,
// tdata = {right_speed, left_speed}. Each sample yields one pose transfer on
// m_axis. Registers (wheel radius, inverse wheel base, sample period) are
// written through cfg_we/cfg_addr/cfg_data, but only while the block is idle:
// the user must keep to this, as the block itself does not enforce it.
// Ten products go through one shared 34x34 signed multiplier, and the CORDIC
// takes one micro-rotation per cycle.
// s_axis_tready is low while a sample is in work
// and while the result waits in the output register; when the receiver stalls
// the result holds and no further sample is taken.
// Reset clears pose, heading and registers to their defaults.
`timescale 1ns / 1ps
`default_nettype none
module diff_drive_odometry_unit #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_addr,
    input  wire logic [15:0]  cfg_data,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [31:0]  s_axis_tdata,   // left_speed, right_speed
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [151:0]      m_axis_tdata    // pos_x, pos_y, heading, body_speed, yaw_rate
);
    import ddo_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_BODY, S_YAW1, S_YAW2, S_RAD, S_BAMLO, S_BAMHI, S_CORDIC,
        S_CWAIT, S_XC, S_XD, S_YC, S_YD, S_OUT
    } state_t;

    state_t state_reg;
    logic [15:0] radius_reg, invwb_reg, period_reg;
    logic signed [31:0] x_reg, y_reg;
    logic [31:0] head_reg;
    logic signed [15:0] left_reg, right_reg;
    logic signed [23:0] body_reg;
    logic signed [31:0] yaw_reg;
    logic signed [63:0] acc_reg;
    logic        neg_reg;
    logic [47:0] mag_reg;
    logic [63:0] bamlo_reg;
    logic signed [31:0] c_reg, s_reg;
    logic        out_valid_reg;

    logic signed [33:0] ma, mb;
    logic signed [67:0] prod;
    logic        cstart, cdone;
    logic [31:0] ccos, csin;
    logic signed [63:0] r1;
    logic signed [63:0] r2;
    logic [63:0] bam_sum;
    logic [31:0] delta;

    ddo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .clk(clk), .rst_n(rst_n), .start(cstart), .angle(head_reg),
        .done(cdone), .cos_out(ccos), .sin_out(csin)
    );

    function automatic logic signed [63:0] sat_s(input logic signed [63:0] v, input int bits);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        begin
            hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
            lo = -hi - 64'sd1;
            return (v > hi) ? hi : ((v < lo) ? lo : v);
        end
    endfunction

    always_comb
    begin
        ma = '0;
        mb = '0;
        case (state_reg)
            S_BODY:  begin ma = 34'(left_reg) + 34'(right_reg); mb = 34'(radius_reg); end
            S_YAW1:  begin ma = 34'(right_reg) - 34'(left_reg); mb = 34'(radius_reg); end
            S_YAW2:  begin ma = 34'(acc_reg[33:0]); mb = 34'(invwb_reg); end
            S_RAD:   begin ma = 34'(yaw_reg); mb = 34'(period_reg); end
            S_BAMLO: begin ma = 34'(mag_reg[23:0]); mb = 34'(RadToBam); end
            S_BAMHI: begin ma = 34'(mag_reg[47:24]); mb = 34'(RadToBam); end
            S_XC:    begin ma = 34'(body_reg); mb = 34'(c_reg); end
            S_YC:    begin ma = 34'(body_reg); mb = 34'(s_reg); end
            S_XD, S_YD: begin ma = 34'(r1); mb = 34'(period_reg); end
            default: begin ma = '0; mb = '0; end
        endcase
        prod = ma * mb;
        r1 = (acc_reg + 64'sd536870912) >>> 30;
        r2 = 64'(prod) + 64'sd32768;
        r2 = r2 >>> 16;
        bam_sum = {8'd0, prod[63:8]} + 64'(((64'(prod[7:0]) << 24) + bamlo_reg
                  + 64'h80000000) >> 32);
        delta = bam_sum[31:0];
    end

    assign cstart = (state_reg == S_CORDIC);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            radius_reg <= 16'd3213;
            invwb_reg <= 16'd14475;
            period_reg <= 16'd3277;
            x_reg <= '0;
            y_reg <= '0;
            head_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    RegWheelRadius:  radius_reg <= cfg_data;
                    RegInvWheelBase: invwb_reg <= cfg_data;
                    RegSamplePeriod: period_reg <= cfg_data;
                    default: ;
                endcase
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid && s_axis_tready)
                    begin
                        left_reg <= s_axis_tdata[15:0];
                        right_reg <= s_axis_tdata[31:16];
                        state_reg <= S_BODY;
                    end
                end
                S_BODY:
                begin
                    body_reg <= 24'(sat_s((64'(prod) + 64'sd256) >>> 9, 24));
                    state_reg <= S_YAW1;
                end
                S_YAW1:
                begin
                    acc_reg <= 64'(prod);
                    state_reg <= S_YAW2;
                end
                S_YAW2:
                begin
                    yaw_reg <= 32'(sat_s((64'(prod) + 64'sd524288) >>> 20, 32));
                    state_reg <= S_RAD;
                end
                S_RAD:
                begin
                    neg_reg <= prod < 0;
                    mag_reg <= (prod < 0) ? 48'(-prod) : 48'(prod);
                    state_reg <= S_BAMLO;
                end
                S_BAMLO:
                begin
                    bamlo_reg <= 64'(prod);
                    state_reg <= S_BAMHI;
                end
                S_BAMHI:
                begin
                    head_reg <= neg_reg ? head_reg - delta : head_reg + delta;
                    state_reg <= S_CORDIC;
                end
                S_CORDIC: state_reg <= S_CWAIT;
                S_CWAIT:
                begin
                    if (cdone)
                    begin
                        c_reg <= ccos;
                        s_reg <= csin;
                        state_reg <= S_XC;
                    end
                end
                S_XC:
                begin
                    acc_reg <= 64'(prod);
                    state_reg <= S_XD;
                end
                S_XD:
                begin
                    x_reg <= 32'(sat_s(64'(x_reg) + r2, 32));
                    state_reg <= S_YC;
                end
                S_YC:
                begin
                    acc_reg <= 64'(prod);
                    state_reg <= S_YD;
                end
                S_YD:
                begin
                    y_reg <= 32'(sat_s(64'(y_reg) + r2, 32));
                    out_valid_reg <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (m_axis_tready)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {yaw_reg, body_reg, head_reg, y_reg, x_reg};

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input accepted while result pending");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_YD) |=> m_axis_tvalid)
        else $error("result not presented");
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("pose changed while stalled");
endmodule
`default_nettype wire

// ===== design/ddo_cordic.sv =====
// Iterative rotation-mode CORDIC: one micro-rotation per clock.
// Depends on ddo_pkg for the arctangent table and start gain.
`timescale 1ns / 1ps
`default_nettype none
module ddo_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] angle,
    output logic             done,
    output logic [31:0]      cos_out,
    output logic [31:0]      sin_out
);
    import ddo_pkg::*;

    localparam int Steps = (CORDIC_STEPS > 31) ? 31 : CORDIC_STEPS;

    logic        busy_reg;
    logic [4:0]  step_reg;
    logic        flip_reg;
    logic signed [33:0] x_reg;
    logic signed [33:0] y_reg;
    logic signed [33:0] z_reg;
    logic        done_reg;

    logic signed [33:0] z_init;
    logic        flip_init;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [33:0] at;
    logic signed [33:0] xf;
    logic signed [33:0] yf;

    always_comb
    begin
        z_init = 34'(signed'(angle));
        flip_init = 1'b0;
        if (z_init > 34'sh40000000)
        begin
            z_init = z_init - 34'sh80000000;
            flip_init = 1'b1;
        end
        else if (z_init < -34'sh40000000)
        begin
            z_init = z_init + 34'sh80000000;
            flip_init = 1'b1;
        end
        dx = y_reg >>> step_reg;
        dy = x_reg >>> step_reg;
        at = 34'(atan_bam(step_reg));
        xf = flip_reg ? -x_reg : x_reg;
        yf = flip_reg ? -y_reg : y_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
                flip_reg <= flip_init;
                x_reg <= 34'(CordicStartX);
                y_reg <= '0;
                z_reg <= z_init;
            end
            else if (busy_reg)
            begin
                if (z_reg >= 0)
                begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - at;
                end
                else
                begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + at;
                end
                if (step_reg == 5'(Steps - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                step_reg <= step_reg + 5'd1;
            end
        end
    end

    assign done = done_reg;
    assign cos_out = xf[31:0];
    assign sin_out = yf[31:0];

    assert property (@(posedge clk) disable iff (!rst_n) done_reg |-> !busy_reg)
        else $error("CORDIC done while still busy");
    assert property (@(posedge clk) disable iff (!rst_n) start |=> busy_reg)
        else $error("CORDIC did not start");
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> step_reg < 5'(Steps))
        else $error("CORDIC step out of range");
endmodule
`default_nettype wire
